// ===== hdl/lufp_pkg.sv =====
// Shared types and constants for the lidar serial frame parser.
`default_nettype none
package lufp_pkg;

    // Frame layout
    localparam int FRAME_BYTES = 9;
    localparam int SUM_BYTES   = 8;
    localparam int FILL_W      = 4;
    localparam logic [7:0] HEADER_BYTE = 8'h59;

    // Configuration register map
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_DISTANCE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DISTANCE = 2'd1;
    localparam logic [15:0] MIN_DISTANCE_RESET = 16'd20;
    localparam logic [15:0] MAX_DISTANCE_RESET = 16'd800;

    // Frame status codes
    localparam logic STATUS_VALID        = 1'b0;
    localparam logic STATUS_OUT_OF_RANGE = 1'b1;

    typedef logic [7:0] byte_t;

    // One decoded frame
    typedef struct packed {
        logic [15:0] distance_cm;
        logic [15:0] signal_strength;
        logic        frame_status;
    } result_t;

endpackage
`default_nettype wire

// ===== hdl/lidar_uart_frame_parser_core.sv =====
// Top level of the lidar serial frame parser.
// Takes one received byte per request and reports each nine-byte frame that starts with
// two 0x59 header bytes and carries a correct modulo-256 checksum. A byte is taken every
// cycle while in_stall is low: the window update and frame check form one short
// combinational pass into the result register, and a one-entry skid stage holds a result
// while the output is stalled; in_stall rises only while that skid stage is occupied.
// Bad frames resynchronize one byte at a time.
// Distances outside [min_distance_cm, max_distance_cm] report frame_status 1 and distance 0.
`default_nettype none
module lidar_uart_frame_parser_core
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [lufp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [lufp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [7:0]                          rx_byte,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [15:0]                              distance_cm,
    output logic [15:0]                              signal_strength,
    output logic                                     frame_status
);
    import lufp_pkg::*;

    logic [15:0] min_distance_reg;
    logic [15:0] max_distance_reg;
    logic        push;
    logic        frame_found;
    logic        busy;
    result_t     frame_result;
    result_t     out_data;

    // Hold the range limits; ignore writes beyond the map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_distance_reg <= MIN_DISTANCE_RESET;
            max_distance_reg <= MAX_DISTANCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_DISTANCE: min_distance_reg <= cfg_data;
                REG_MAX_DISTANCE: max_distance_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_stall = busy;
    assign push     = in_valid && !busy;

    lufp_window u_window
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .rx_byte         (rx_byte),
        .min_distance_cm (min_distance_reg),
        .max_distance_cm (max_distance_reg),
        .frame_found     (frame_found),
        .frame_result    (frame_result)
    );

    lufp_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (frame_found),
        .load_data (frame_result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .busy      (busy)
    );

    assign distance_cm     = out_data.distance_cm;
    assign signal_strength = out_data.signal_strength;
    assign frame_status    = out_data.frame_status;

endmodule
`default_nettype wire

// ===== hdl/lufp_window.sv =====
// Sliding byte window, frame check and field decode.
`default_nettype none
module lufp_window
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire lufp_pkg::byte_t rx_byte,
    input  wire logic [15:0]     min_distance_cm,
    input  wire logic [15:0]     max_distance_cm,
    output logic                 frame_found,
    output lufp_pkg::result_t    frame_result
);
    import lufp_pkg::*;

    byte_t             window_reg [FRAME_BYTES];
    byte_t             window_next [FRAME_BYTES];
    byte_t             shifted [FRAME_BYTES];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_pushed;
    logic [7:0]        sum;
    logic              frame_ok;
    logic [15:0]       distance;
    logic              out_of_range;

    // Append the new byte, or drop the oldest when the window is full
    always_comb
    begin
        if (fill_reg < FILL_W'(FRAME_BYTES))
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                shifted[i] = (fill_reg == FILL_W'(i)) ? rx_byte : window_reg[i];
            end
            fill_pushed = fill_reg + FILL_W'(1);
        end
        else
        begin
            for (int i = 0; i < FRAME_BYTES - 1; i++)
            begin
                shifted[i] = window_reg[i + 1];
            end
            shifted[FRAME_BYTES-1] = rx_byte;
            fill_pushed = fill_reg;
        end
    end

    // Check header and checksum on the updated window
    always_comb
    begin
        sum = 8'd0;
        for (int i = 0; i < SUM_BYTES; i++)
        begin
            sum = sum + shifted[i];
        end
        frame_ok = (fill_pushed == FILL_W'(FRAME_BYTES)) &&
                   (shifted[0] == HEADER_BYTE) && (shifted[1] == HEADER_BYTE) &&
                   (shifted[SUM_BYTES] == sum);
    end

    // Decode fields and range-check the distance
    always_comb
    begin
        distance     = {shifted[3], shifted[2]};
        out_of_range = (distance < min_distance_cm) || (distance > max_distance_cm);
        frame_result.distance_cm     = out_of_range ? 16'd0 : distance;
        frame_result.signal_strength = {shifted[5], shifted[4]};
        frame_result.frame_status    = out_of_range ? STATUS_OUT_OF_RANGE : STATUS_VALID;
        frame_found = push && frame_ok;
    end

    // Empty the window after a frame, otherwise keep the pushed window
    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            window_next[i] = window_reg[i];
        end
        fill_next = fill_reg;
        if (push)
        begin
            if (frame_ok)
            begin
                for (int i = 0; i < FRAME_BYTES; i++)
                begin
                    window_next[i] = 8'd0;
                end
                fill_next = '0;
            end
            else
            begin
                for (int i = 0; i < FRAME_BYTES; i++)
                begin
                    window_next[i] = shifted[i];
                end
                fill_next = fill_pushed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                window_reg[i] <= 8'd0;
            end
        end
        else
        begin
            fill_reg <= fill_next;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                window_reg[i] <= window_next[i];
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/lufp_out_buf.sv =====
// Result register with a skid stage toward the downstream channel.
`default_nettype none
module lufp_out_buf
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire lufp_pkg::result_t load_data,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output lufp_pkg::result_t      out_data,
    output logic                   busy
);
    import lufp_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    // Advance results; park a new one in the skid stage while stalled
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = load;
                out_data_next  = load_data;
            end
        end
        else if (load)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = load_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign busy      = skid_valid_reg;

endmodule
`default_nettype wire
